// ----- sv/nktl_pkg.sv -----
// ----------------------------------------------------------------------------
// nktl_pkg
// shared types, codes and helpers for the nearest key table lookup
// ----------------------------------------------------------------------------
package nktl_pkg;

    localparam int VAL_W   = 32;
    localparam int ROW_W   = 3 * VAL_W;
    localparam int DIST_W  = 31;
    localparam int ENT_W   = 11;
    localparam int IDX_W   = 10;
    localparam int KIND_W  = 3;
    localparam int CIDX_W  = 1;

    localparam logic [DIST_W-1:0] DIST_MAX      = 31'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] WINDOW_RESET  = 31'd655360;
    localparam logic [ENT_W-1:0]  ENTRIES_RESET = 11'd1024;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_ENTRIES = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_WINDOW  = 1'b1;

    localparam logic [KIND_W-1:0] QK_DENS_ENER = 3'd0;
    localparam logic [KIND_W-1:0] QK_DENS_PRES = 3'd1;
    localparam logic [KIND_W-1:0] QK_ENER_PRES = 3'd2;
    localparam logic [KIND_W-1:0] QK_ENER_DENS = 3'd3;
    localparam logic [KIND_W-1:0] QK_PRES_ENER = 3'd4;

    typedef enum logic [1:0] {
        COL_DENS,
        COL_ENER,
        COL_PRES
    } col_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_RESULT
    } state_t;

    function automatic logic kind_valid(input logic [KIND_W-1:0] kind);
        logic ok;
        case (kind)
            QK_DENS_ENER, QK_DENS_PRES, QK_ENER_PRES,
            QK_ENER_DENS, QK_PRES_ENER: ok = 1'b1;
            default:                    ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic col_t key_col(input logic [KIND_W-1:0] kind);
        col_t c;
        case (kind)
            QK_DENS_ENER, QK_DENS_PRES: c = COL_DENS;
            QK_ENER_PRES, QK_ENER_DENS: c = COL_ENER;
            default:                    c = COL_PRES;
        endcase
        return c;
    endfunction

    function automatic col_t res_col(input logic [KIND_W-1:0] kind);
        col_t c;
        case (kind)
            QK_DENS_ENER: c = COL_ENER;
            QK_DENS_PRES: c = COL_PRES;
            QK_ENER_PRES: c = COL_PRES;
            QK_ENER_DENS: c = COL_DENS;
            default:      c = COL_ENER;
        endcase
        return c;
    endfunction

    // row layout: pressure, energy, density from msb to lsb
    function automatic logic [VAL_W-1:0] col_pick(input col_t c, input logic [ROW_W-1:0] row);
        logic [VAL_W-1:0] v;
        case (c)
            COL_DENS: v = row[VAL_W-1:0];
            COL_ENER: v = row[2*VAL_W-1:VAL_W];
            COL_PRES: v = row[3*VAL_W-1:2*VAL_W];
            default:  v = row[VAL_W-1:0];
        endcase
        return v;
    endfunction

endpackage

// ----- sv/nktl_if.sv -----
// ----------------------------------------------------------------------------
// nktl_req_if / nktl_rsp_if
// valid/ready channels for request items and lookup results
// ----------------------------------------------------------------------------
interface nktl_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [nktl_pkg::IDX_W-1:0]          row_index;
    logic signed [nktl_pkg::VAL_W-1:0]   row_density;
    logic signed [nktl_pkg::VAL_W-1:0]   row_energy;
    logic signed [nktl_pkg::VAL_W-1:0]   row_pressure;
    logic [nktl_pkg::KIND_W-1:0]         query_kind;
    logic signed [nktl_pkg::VAL_W-1:0]   query_key;

    modport source (
        output valid, req_type, row_index, row_density, row_energy, row_pressure,
               query_kind, query_key,
        input  ready
    );
    modport sink (
        input  valid, req_type, row_index, row_density, row_energy, row_pressure,
               query_kind, query_key,
        output ready
    );
endinterface

interface nktl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [nktl_pkg::VAL_W-1:0]   result_value;
    logic [nktl_pkg::IDX_W-1:0]          matched_row;

    modport source (
        output valid, result_value, matched_row,
        input  ready
    );
    modport sink (
        input  valid, result_value, matched_row,
        output ready
    );
endinterface

// ----- sv/nearest_key_table_lookup.sv -----
// timing: a load is written in its transfer cycle; a query scans the rows in use
// (clamped to depth) but the last, then drains, fetches the best row and registers its result
// throughput: one item at a time; a query holds the block through its scan and
// result, the scan using the single table memory port at one row a cycle
// reset: state, valid and config registers return to defaults (1024 rows, window 10.0); the
// table itself is not cleared and holds whatever was loaded
// ----------------------------------------------------------------------------
// nearest_key_table_lookup
// row table in one synchronous memory, scanned row by row for the nearest key
// ----------------------------------------------------------------------------
module nearest_key_table_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nktl_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [nktl_pkg::DIST_W-1:0]         cfg_wdata,
    nktl_req_if.sink                            req,
    nktl_rsp_if.source                          rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // table memory
    logic [nktl_pkg::ROW_W-1:0] mem [TABLE_DEPTH];
    logic [nktl_pkg::ROW_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;
    logic [nktl_pkg::ROW_W-1:0] mem_wdata;

    // configuration
    logic [nktl_pkg::ENT_W-1:0]  entries_reg;
    logic [nktl_pkg::DIST_W-1:0] window_reg;

    // control
    nktl_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]    scan_len_reg, scan_len_next;
    nktl_pkg::col_t   kc_reg, kc_next;
    nktl_pkg::col_t   rc_reg, rc_next;
    logic [nktl_pkg::VAL_W-1:0] key_reg, key_next;

    // scan pipeline
    logic                        v1_reg, v1_next;
    logic                        v2_reg, v2_next;
    logic [AW-1:0]               row1_reg, row1_next;
    logic [AW-1:0]               row2_reg, row2_next;
    logic [nktl_pkg::DIST_W-1:0] dist2_reg, dist2_next;
    logic                        have_best_reg, have_best_next;
    logic [nktl_pkg::DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [AW-1:0]               best_row_reg, best_row_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [nktl_pkg::VAL_W-1:0]  out_value_reg, out_value_next;
    logic [nktl_pkg::IDX_W-1:0]  out_row_reg, out_row_next;

    logic        req_xfer;
    logic        rsp_xfer;
    logic        load_ok;
    logic        query_ok;
    logic [31:0] row_idx_wide;
    logic [31:0] ent_wide;
    logic [31:0] cnt_wide;
    logic [31:0] len_wide;
    logic [31:0] best_wide;
    logic        scan_last;
    logic        drained;
    logic        res_load;
    logic [nktl_pkg::VAL_W-1:0] col_val;
    logic [nktl_pkg::VAL_W:0]   diff_a;
    logic [nktl_pkg::VAL_W:0]   diff_b;
    logic [nktl_pkg::VAL_W:0]   diff_abs;
    logic                       take;

    assign req.ready  = (state_reg == nktl_pkg::ST_IDLE);
    assign req_xfer   = req.valid && req.ready;
    assign rsp_xfer   = out_valid_reg && rsp.ready;

    assign row_idx_wide = {22'd0, req.row_index};
    assign load_ok  = req_xfer && (req.req_type == nktl_pkg::REQ_LOAD)
                      && (row_idx_wide < TABLE_DEPTH);
    assign query_ok = req_xfer && (req.req_type == nktl_pkg::REQ_QUERY)
                      && nktl_pkg::kind_valid(req.query_kind);

    assign ent_wide  = {21'd0, entries_reg};
    assign cnt_wide  = (ent_wide > TABLE_DEPTH) ? TABLE_DEPTH : ent_wide;
    assign len_wide  = (cnt_wide == 32'd0) ? 32'd0 : cnt_wide - 32'd1;
    assign best_wide = {{(32-AW){1'b0}}, best_row_reg};

    assign scan_last = (rd_idx_reg == scan_len_reg - AW'(1));
    assign drained   = !v1_reg && !v2_reg;
    assign res_load  = (state_reg == nktl_pkg::ST_RESULT) && (!out_valid_reg || rsp.ready);

    // distance stage
    assign col_val  = nktl_pkg::col_pick(kc_reg, rd_data_reg);
    assign diff_a   = {col_val[nktl_pkg::VAL_W-1], col_val} - {key_reg[nktl_pkg::VAL_W-1], key_reg};
    assign diff_b   = {key_reg[nktl_pkg::VAL_W-1], key_reg} - {col_val[nktl_pkg::VAL_W-1], col_val};
    assign diff_abs = diff_a[nktl_pkg::VAL_W] ? diff_b : diff_a;

    // compare stage
    assign take = v2_reg && (!have_best_reg || (dist2_reg < best_dist_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nktl_pkg::ST_IDLE:
            begin
                if (query_ok)
                begin
                    if (len_wide == 32'd0)
                        state_next = nktl_pkg::ST_FETCH;
                    else
                        state_next = nktl_pkg::ST_SCAN;
                end
            end
            nktl_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = nktl_pkg::ST_DRAIN;
            end
            nktl_pkg::ST_DRAIN:
            begin
                if (drained)
                    state_next = nktl_pkg::ST_FETCH;
            end
            nktl_pkg::ST_FETCH:
            begin
                state_next = nktl_pkg::ST_RESULT;
            end
            nktl_pkg::ST_RESULT:
            begin
                if (res_load)
                    state_next = nktl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nktl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = row_idx_wide[AW-1:0];
        mem_wdata      = {req.row_pressure, req.row_energy, req.row_density};
        rd_idx_next    = rd_idx_reg;
        scan_len_next  = scan_len_reg;
        kc_next        = kc_reg;
        rc_next        = rc_reg;
        key_next       = key_reg;
        v1_next        = 1'b0;
        row1_next      = row1_reg;
        v2_next        = v1_reg;
        row2_next      = row1_reg;
        dist2_next     = dist2_reg;
        have_best_next = have_best_reg;
        best_dist_next = best_dist_reg;
        best_row_next  = best_row_reg;
        out_valid_next = out_valid_reg && !rsp_xfer;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;

        if (v1_reg)
        begin
            if (diff_abs[nktl_pkg::VAL_W:nktl_pkg::VAL_W-1] != 2'b00)
                dist2_next = nktl_pkg::DIST_MAX;
            else
                dist2_next = diff_abs[nktl_pkg::DIST_W-1:0];
        end

        if (take)
        begin
            have_best_next = 1'b1;
            best_dist_next = dist2_reg;
            best_row_next  = row2_reg;
        end

        case (state_reg)
            nktl_pkg::ST_IDLE:
            begin
                mem_we = load_ok;
                if (query_ok)
                begin
                    rd_idx_next   = '0;
                    scan_len_next = len_wide[AW-1:0];
                    kc_next       = nktl_pkg::key_col(req.query_kind);
                    rc_next       = nktl_pkg::res_col(req.query_kind);
                    key_next      = req.query_key;
                    best_row_next = '0;
                    if (nktl_pkg::key_col(req.query_kind) == nktl_pkg::COL_DENS)
                    begin
                        have_best_next = 1'b1;
                        best_dist_next = window_reg;
                    end
                    else
                    begin
                        have_best_next = 1'b0;
                        best_dist_next = nktl_pkg::DIST_MAX;
                    end
                end
            end
            nktl_pkg::ST_SCAN:
            begin
                mem_re      = 1'b1;
                mem_addr    = rd_idx_reg;
                v1_next     = 1'b1;
                row1_next   = rd_idx_reg;
                rd_idx_next = rd_idx_reg + AW'(1);
            end
            nktl_pkg::ST_FETCH:
            begin
                mem_re   = 1'b1;
                mem_addr = best_row_reg;
            end
            nktl_pkg::ST_RESULT:
            begin
                if (res_load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = nktl_pkg::col_pick(rc_reg, rd_data_reg);
                    out_row_next   = best_wide[nktl_pkg::IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nktl_pkg::ST_IDLE;
            entries_reg   <= nktl_pkg::ENTRIES_RESET;
            window_reg    <= nktl_pkg::WINDOW_RESET;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == nktl_pkg::CFG_ENTRIES))
                entries_reg <= cfg_wdata[nktl_pkg::ENT_W-1:0];
            if (cfg_we && (cfg_index == nktl_pkg::CFG_WINDOW))
                window_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        scan_len_reg  <= scan_len_next;
        kc_reg        <= kc_next;
        rc_reg        <= rc_next;
        key_reg       <= key_next;
        row1_reg      <= row1_next;
        row2_reg      <= row2_next;
        dist2_reg     <= dist2_next;
        have_best_reg <= have_best_next;
        best_dist_reg <= best_dist_next;
        best_row_reg  <= best_row_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.matched_row  = out_row_reg;

`ifndef SYNTHESIS
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nktl_pkg::ST_IDLE) |-> !mem_we)
        else $error("table written during a query");

    a_fetch_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nktl_pkg::ST_FETCH) |-> (!v1_reg && !v2_reg))
        else $error("result fetch before scan pipeline drained");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nktl_pkg::ST_FETCH)
        |-> ((best_row_reg == '0) || (best_row_reg < scan_len_reg)))
        else $error("chosen row outside scanned range");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == nktl_pkg::ST_RESULT))
        else $error("result raised outside result state");

    a_take_improves: assert property (@(posedge clk) disable iff (!rst_n)
        (take && have_best_reg) |=> (best_dist_reg < $past(best_dist_reg)))
        else $error("best distance did not improve");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// nearest key table lookup: fills the row table, then runs directed corner
// queries, a long result stall and random load/query traffic over many
// register settings; each result is checked against a local table model
// ----------------------------------------------------------------------------
module tb;
    import nktl_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int FILL_ROWS   = 128;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic                    req_type;
        logic [IDX_W-1:0]        row_index;
        logic signed [VAL_W-1:0] dens;
        logic signed [VAL_W-1:0] ener;
        logic signed [VAL_W-1:0] pres;
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] key;
    } table_req_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        row;
    } lookup_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CIDX_W-1:0]   cfg_index;
    logic [DIST_W-1:0]   cfg_wdata;

    nktl_req_if req_ch ();
    nktl_rsp_if rsp_ch ();

    nearest_key_table_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // local copy of the table and registers
    logic signed [VAL_W-1:0] tbl_dens [DEPTH];
    logic signed [VAL_W-1:0] tbl_ener [DEPTH];
    logic signed [VAL_W-1:0] tbl_pres [DEPTH];
    logic [ENT_W-1:0]        rows_in_use = ENTRIES_RESET;
    logic [DIST_W-1:0]       window      = WINDOW_RESET;

    lookup_t pending_lookups [$];

    int failures      = 0;
    int cycle_count   = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 76;
    int hold_request  = 0;
    int hold_left     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** nearest_key_table_lookup: FAILED **");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("unexpected result: result_value %h matched_row %0d",
                       rsp_ch.result_value, rsp_ch.matched_row);
                failures++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.result_value !== want.value)
                begin
                    $error("result_value: expected %h, got %h", want.value, rsp_ch.result_value);
                    failures++;
                end
                if (rsp_ch.matched_row !== want.row)
                begin
                    $error("matched_row: expected %0d, got %0d", want.row, rsp_ch.matched_row);
                    failures++;
                end
            end
        end
    end

    function automatic int scan_count();
        return (rows_in_use > DEPTH) ? DEPTH : int'(rows_in_use);
    endfunction

    function automatic void kind_columns(input logic [KIND_W-1:0] kind,
                                         output col_t kc, output col_t rc);
        case (kind)
            QK_DENS_ENER:
            begin
                kc = COL_DENS;
                rc = COL_ENER;
            end
            QK_DENS_PRES:
            begin
                kc = COL_DENS;
                rc = COL_PRES;
            end
            QK_ENER_PRES:
            begin
                kc = COL_ENER;
                rc = COL_PRES;
            end
            QK_ENER_DENS:
            begin
                kc = COL_ENER;
                rc = COL_DENS;
            end
            default:
            begin
                kc = COL_PRES;
                rc = COL_ENER;
            end
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] table_value(input col_t c, input int r);
        logic signed [VAL_W-1:0] v;
        case (c)
            COL_DENS: v = tbl_dens[r];
            COL_ENER: v = tbl_ener[r];
            default:  v = tbl_pres[r];
        endcase
        return v;
    endfunction

    function automatic logic [DIST_W-1:0] key_distance(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (d < 0)
            d = -d;
        return d[VAL_W-1] ? DIST_MAX : d[DIST_W-1:0];
    endfunction

    function automatic lookup_t predict_lookup(input logic [KIND_W-1:0] kind,
                                               input logic signed [VAL_W-1:0] key);
        col_t             kc;
        col_t             rc;
        int               rows;
        int               best_row;
        logic             have_best;
        logic [DIST_W-1:0] best_dist;
        logic [DIST_W-1:0] d;
        lookup_t          res;
        kind_columns(kind, kc, rc);
        rows     = scan_count();
        best_row = 0;
        // density keys start from the window, others take the first row
        if (kc == COL_DENS)
        begin
            have_best = 1'b1;
            best_dist = window;
        end
        else
        begin
            have_best = 1'b0;
            best_dist = DIST_MAX;
        end
        for (int i = 0; i + 1 < rows; i++)
        begin
            d = key_distance(table_value(kc, i), key);
            if (!have_best || d < best_dist)
            begin
                have_best = 1'b1;
                best_dist = d;
                best_row  = i;
            end
        end
        res.value = table_value(rc, best_row);
        res.row   = best_row[IDX_W-1:0];
        return res;
    endfunction

    function automatic table_req_t make_load(input int row,
                                             input logic signed [VAL_W-1:0] d,
                                             input logic signed [VAL_W-1:0] e,
                                             input logic signed [VAL_W-1:0] p);
        table_req_t it;
        it.req_type  = REQ_LOAD;
        it.row_index = row[IDX_W-1:0];
        it.dens      = d;
        it.ener      = e;
        it.pres      = p;
        it.kind      = KIND_W'($urandom);
        it.key       = $urandom;
        return it;
    endfunction

    function automatic table_req_t make_query(input logic [KIND_W-1:0] kind,
                                              input logic signed [VAL_W-1:0] key);
        table_req_t it;
        it.req_type  = REQ_QUERY;
        it.row_index = IDX_W'($urandom);
        it.dens      = $urandom;
        it.ener      = $urandom;
        it.pres      = $urandom;
        it.kind      = kind;
        it.key       = key;
        return it;
    endfunction

    // clustered values so that ties and window hits are common
    function automatic logic signed [VAL_W-1:0] gen_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            case ($urandom_range(5))
                0:       return 32'sh0000_0000;
                1:       return 32'sh0001_0000;
                2:       return -32'sh0001_0000;
                3:       return 32'sh0005_8000;
                4:       return VAL_MAX;
                default: return VAL_MIN;
            endcase
        end
        else if (pick < 70)
            return int'($urandom_range(0, 2621440)) - 1310720;
        else if (pick < 90)
            return $urandom;
        else
        begin
            case ($urandom_range(3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return 32'sh0000_0000;
                default: return -32'sh0000_0001;
            endcase
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] gen_key(input logic [KIND_W-1:0] kind);
        col_t                    kc;
        col_t                    rc;
        int                      pick;
        int                      r;
        int                      off;
        logic signed [VAL_W-1:0] base;
        kind_columns(kind, kc, rc);
        r    = $urandom_range(0, (scan_count() >= 2) ? scan_count() - 2 : 0);
        base = table_value(kc, r);
        pick = $urandom_range(99);
        if (pick < 35)
            return base;
        else if (pick < 70)
        begin
            off = int'($urandom_range(0, 1310720));
            if ($urandom_range(1))
                off = -off;
            return base + off;
        end
        else if (pick < 88)
            return $urandom;
        else
            return $urandom_range(1) ? VAL_MAX : VAL_MIN;
    endfunction

    function automatic table_req_t random_item();
        int                pick;
        int                row;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(99) < 60 && scan_count() > 0)
                row = $urandom_range(0, scan_count() - 1);
            else
                row = $urandom_range(0, DEPTH - 1);
            return make_load(row, gen_value(), gen_value(), gen_value());
        end
        else if (pick < 95)
        begin
            kind = KIND_W'($urandom_range(QK_DENS_ENER, QK_PRES_ENER));
            return make_query(kind, gen_key(kind));
        end
        else
        begin
            kind = KIND_W'($urandom_range(QK_PRES_ENER + 1, (1 << KIND_W) - 1));
            return make_query(kind, $urandom);
        end
    endfunction

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIST_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ENTRIES)
            rows_in_use = v[ENT_W-1:0];
        else
            window = v;
        @(posedge clk);
    endtask

    task automatic send_item(input table_req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= it.req_type;
        req_ch.row_index    <= it.row_index;
        req_ch.row_density  <= it.dens;
        req_ch.row_energy   <= it.ener;
        req_ch.row_pressure <= it.pres;
        req_ch.query_kind   <= it.kind;
        req_ch.query_key    <= it.key;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        // transfer done
        if (it.req_type == REQ_LOAD)
        begin
            tbl_dens[it.row_index] = it.dens;
            tbl_ener[it.row_index] = it.ener;
            tbl_pres[it.row_index] = it.pres;
        end
        else if (it.kind <= QK_PRES_ENER)
        begin
            pending_lookups = {pending_lookups, predict_lookup(it.kind, it.key)};
        end
    endtask

    // stop sending, wait for all results, then let a full scan time pass
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (scan_count() + 8)
            @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        logic [KIND_W-1:0] kind;
        write_reg(CFG_ENTRIES, DIST_W'(FILL_ROWS + 1));
        for (int r = 0; r < FILL_ROWS; r++)
            send_item(make_load(r, gen_value(), gen_value(), gen_value()));
        for (int k = QK_DENS_ENER; k <= QK_PRES_ENER; k++)
            send_item(make_query(KIND_W'(k), gen_key(KIND_W'(k))));
        repeat (3)
        begin
            kind = KIND_W'($urandom_range(QK_DENS_ENER, QK_PRES_ENER));
            send_item(make_query(kind, gen_key(kind)));
        end
        settle();
    endtask

    task automatic test_directed();
        write_reg(CFG_ENTRIES, DIST_W'(5));
        write_reg(CFG_WINDOW, WINDOW_RESET);
        send_item(make_load(0, 32'sh0000_0000, 32'sh0000_006F, 32'sh0000_00DE));
        send_item(make_load(1, VAL_MAX, VAL_MIN, VAL_MAX));
        send_item(make_load(2, VAL_MIN, VAL_MAX, VAL_MIN));
        send_item(make_load(3, 32'sh0005_0000, VAL_MAX, -32'sh0000_0001));
        send_item(make_load(4, 32'sh0123_4567, 32'sh0000_0001, 32'sh0000_0002));
        // exact hits at the extremes
        send_item(make_query(QK_DENS_ENER, VAL_MIN));
        send_item(make_query(QK_DENS_PRES, VAL_MAX));
        send_item(make_query(QK_ENER_PRES, VAL_MAX));
        send_item(make_query(QK_ENER_DENS, VAL_MIN));
        send_item(make_query(QK_PRES_ENER, VAL_MIN));
        // last row in use is never scanned, nothing inside the window
        send_item(make_query(QK_DENS_ENER, 32'sh0123_4567));
        // tie keeps the earlier row, then a nearer later row wins
        send_item(make_query(QK_DENS_PRES, 32'sh0002_8000));
        send_item(make_query(QK_DENS_ENER, 32'sh0004_0000));
        send_item(make_query(QK_PRES_ENER, 32'sh0000_0000));
        // unknown kinds give nothing
        for (int k = QK_PRES_ENER + 1; k < (1 << KIND_W); k++)
            send_item(make_query(KIND_W'(k), $urandom));
        settle();
        // fewer than two rows in use
        write_reg(CFG_ENTRIES, DIST_W'(1));
        send_item(make_query(QK_DENS_ENER, 32'sh0000_0000));
        settle();
        write_reg(CFG_ENTRIES, '0);
        send_item(make_query(QK_PRES_ENER, VAL_MAX));
        settle();
        // zero window rejects even an exact density match
        write_reg(CFG_ENTRIES, DIST_W'(3));
        write_reg(CFG_WINDOW, '0);
        send_item(make_query(QK_DENS_ENER, VAL_MAX));
        settle();
        // widest window, saturated distances stay out
        write_reg(CFG_WINDOW, DIST_MAX);
        send_item(make_query(QK_DENS_ENER, VAL_MIN));
        send_item(make_query(QK_DENS_PRES, 32'sh4000_0000));
        send_item(make_query(QK_PRES_ENER, VAL_MIN));
        settle();
        // largest loaded table in use
        write_reg(CFG_ENTRIES, DIST_W'(FILL_ROWS + 1));
        write_reg(CFG_WINDOW, WINDOW_RESET);
        send_item(make_query(QK_DENS_ENER, gen_key(QK_DENS_ENER)));
        send_item(make_query(QK_ENER_DENS, gen_key(QK_ENER_DENS)));
        settle();
    endtask

    task automatic test_backpressure();
        int                saved_idle;
        logic [KIND_W-1:0] kind;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        write_reg(CFG_ENTRIES, DIST_W'(6));
        hold_request = 400;
        repeat (8)
        begin
            kind = KIND_W'($urandom_range(QK_DENS_ENER, QK_PRES_ENER));
            send_item(make_query(kind, gen_key(kind)));
        end
        settle();
        repeat (4)
        begin
            send_item(make_load($urandom_range(0, 5), gen_value(), gen_value(), gen_value()));
            kind = KIND_W'($urandom_range(QK_DENS_ENER, QK_PRES_ENER));
            send_item(make_query(kind, gen_key(kind)));
        end
        send_idle_pct = saved_idle;
        settle();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct);
        int         pick;
        int         done;
        table_req_t it;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            pick = $urandom_range(99);
            if (pick < 4)
                write_reg(CFG_ENTRIES, DIST_W'($urandom_range(0, 1)));
            else if (pick < 8)
                write_reg(CFG_ENTRIES, DIST_W'(FILL_ROWS + 1));
            else if (pick < 18)
                write_reg(CFG_ENTRIES, DIST_W'($urandom_range(41, FILL_ROWS + 1)));
            else
                write_reg(CFG_ENTRIES, DIST_W'($urandom_range(2, 40)));
            pick = $urandom_range(99);
            if (pick < 15)
                write_reg(CFG_WINDOW, '0);
            else if (pick < 25)
                write_reg(CFG_WINDOW, DIST_MAX);
            else if (pick < 45)
                write_reg(CFG_WINDOW, WINDOW_RESET);
            else if (pick < 80)
                write_reg(CFG_WINDOW, DIST_W'($urandom_range(0, 50 << 16)));
            else
                write_reg(CFG_WINDOW, DIST_W'($urandom >> 1));
            done = 0;
            while (done < 16)
            begin
                it = random_item();
                send_item(it);
                if (it.req_type == REQ_LOAD || it.kind <= QK_PRES_ENER)
                    done++;
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_ENTRIES;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOAD;
        req_ch.row_index    = '0;
        req_ch.row_density  = '0;
        req_ch.row_energy   = '0;
        req_ch.row_pressure = '0;
        req_ch.query_kind   = QK_DENS_ENER;
        req_ch.query_key    = '0;
        rsp_ch.ready        = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random_traffic(10, 76);
        test_random_traffic(76, 10);
        test_random_traffic(0, 0);

        settle();
        if (failures == 0 && pending_lookups.size() == 0)
            $display("** nearest_key_table_lookup: PASSED **");
        else
            $display("** nearest_key_table_lookup: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/nktl_pkg.sv
sv/nktl_if.sv
sv/nearest_key_table_lookup.sv
test/tb.sv
